### rtl/lrsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrsc_pkg;

    localparam int MAX_RAYS_DEF   = 360;
    localparam int COORD_BITS_DEF = 24;

    localparam logic [22:0] RANGE_RESET = 23'h7FFFFF;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;

    localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] REG_HEADING   = 3'd2;
    localparam logic [2:0] REG_MIN_ANGLE = 3'd3;
    localparam logic [2:0] REG_RAY_COUNT = 3'd4;
    localparam logic [2:0] REG_MAX_RANGE = 3'd5;

    localparam logic [1:0] CMD_SEGMENT = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;
    localparam logic [1:0] CMD_NOP     = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_SEG_MUL,
        S_SEG_TN,
        S_TRIG,
        S_RVEC,
        S_CROSS,
        S_DEN,
        S_TEST,
        S_DIV,
        S_SQ,
        S_SUM,
        S_SQRT,
        S_WB
    } lrsc_state_t;

    // Q15 sine of 0..90 degrees, Taylor series in Q30, evaluated at elaboration
    function automatic logic [91*16-1:0] build_sin_table();
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic [63:0]        q;
        logic signed [63:0] sum;
        logic [91*16-1:0]   tab;
        tab = '0;
        for (int d = 0; d <= 90; d++) begin
            x   = 64'(d) * PI_Q30 / 64'd180;
            x2  = (x * x) >> 30;
            t   = x;
            sum = $signed(x);
            for (int k = 1; k <= 7; k++) begin
                t = (t * x2) >> 30;
                unique case (k)
                    1:       t = t / 64'd6;
                    2:       t = t / 64'd20;
                    3:       t = t / 64'd42;
                    4:       t = t / 64'd72;
                    5:       t = t / 64'd110;
                    6:       t = t / 64'd156;
                    default: t = t / 64'd210;
                endcase
                if ((k % 2) == 1) sum = sum - $signed(t);
                else              sum = sum + $signed(t);
            end
            if (sum < 0) sum = '0;
            q = ($unsigned(sum) + 64'd16384) >> 15;
            if (q > 64'd32767) q = 64'd32767;
            tab[d*16 +: 16] = q[15:0];
        end
        return tab;
    endfunction

    localparam logic [91*16-1:0] SIN_TABLE = build_sin_table();

    // angle in 0..359 degrees
    function automatic logic signed [15:0] sin_deg(input logic [8:0] a);
        logic [8:0]  idx;
        logic        neg;
        logic [15:0] v;
        if (a <= 9'd90) begin
            idx = a;
            neg = 1'b0;
        end else if (a <= 9'd180) begin
            idx = 9'd180 - a;
            neg = 1'b0;
        end else if (a <= 9'd270) begin
            idx = a - 9'd180;
            neg = 1'b1;
        end else begin
            idx = 9'd360 - a;
            neg = 1'b1;
        end
        v = SIN_TABLE[idx[6:0]*16 +: 16];
        return neg ? -$signed(v) : $signed(v);
    endfunction

endpackage

`default_nettype wire

### rtl/lidar_ray_segment_caster.sv
// Simulated 2D lidar. Configure the pose and ray fan through the cfg channel
// (always ready), then issue commands with start while busy is low: cmd 0 casts
// one wall segment against every ray, cmd 1 reads one ray's nearest distance
// (read in state S_RD, then strobed on done from a register, one cycle wide, cannot
// be stalled), cmd 2 refills the range store with max_range, cmd 3 is ignored.
// The store is a single-port-write synchronous RAM; after reset and on cmd 2
// the block sweeps all MAX_RAYS entries, one entry a cycle, with busy high.
// A segment runs S_SEG_MUL and S_SEG_TN, then per ray S_TRIG through S_TEST;
// a hit adds a 24-step multiply-divide per axis and a 24-step square root.
`timescale 1ns / 1ps
`default_nettype none

module lidar_ray_segment_caster
    import lrsc_pkg::*;
#(
    parameter int MAX_RAYS   = MAX_RAYS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   cmd,
    input  wire logic signed [COORD_BITS-1:0] seg_start_x,
    input  wire logic signed [COORD_BITS-1:0] seg_start_y,
    input  wire logic signed [COORD_BITS-1:0] seg_end_x,
    input  wire logic signed [COORD_BITS-1:0] seg_end_y,
    input  wire logic [8:0]                   ray_index,
    output logic                              done,
    output logic [8:0]                        read_ray,
    output logic [22:0]                       distance,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [2:0]                   cfg_index,
    input  wire logic [23:0]                  cfg_data
);

    localparam int AW    = (MAX_RAYS > 1) ? $clog2(MAX_RAYS) : 1;
    localparam int CW    = $clog2(MAX_RAYS + 1);
    localparam int IW    = (AW > 9) ? AW : 9;
    localparam int SW    = COORD_BITS + 1;
    localparam int WW    = ((COORD_BITS > 24) ? COORD_BITS : 24) + 1;
    localparam int PW_RS = 24 + SW;
    localparam int PW_WS = WW + SW;
    localparam int PW_WR = WW + 24;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    // configuration
    logic signed [23:0] origin_x_reg, origin_y_reg;
    logic [8:0]         heading_reg;
    logic signed [9:0]  min_angle_reg;
    logic [8:0]         ray_count_reg;
    logic [22:0]        max_range_reg;

    lrsc_state_t state_reg, state_next;

    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      n_rays;
    logic [22:0]        fill_reg;
    logic [8:0]         angle_reg;
    logic [8:0]         angle0;
    logic [8:0]         rd_idx_reg;
    logic               oor_reg;
    logic               done_reg;
    logic [8:0]         read_ray_reg;
    logic [22:0]        distance_reg;

    logic signed [SW-1:0] sx_reg, sy_reg;
    logic signed [WW-1:0] wx_reg, wy_reg;
    logic signed [63:0]   tp1_reg, tp2_reg, tn_reg;
    logic signed [39:0]   prx_reg, pry_reg;
    logic signed [23:0]   rx_reg, ry_reg;
    logic signed [63:0]   dp1_reg, dp2_reg, up1_reg, up2_reg;
    logic signed [63:0]   den_reg, un_reg;
    logic [22:0]          cur_reg;

    logic [62:0] num_reg, dv_reg;
    logic [23:0] mulx_reg, muly_reg;
    logic [64:0] remx_reg, remy_reg;
    logic [24:0] qx_reg, qy_reg;
    logic [4:0]  div_cnt_reg;
    logic [47:0] hx2_reg, hy2_reg;
    logic [47:0] sq_n_reg, sq_res_reg, sq_bit_reg;

    // memory
    logic [22:0]   mem [MAX_RAYS];
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [22:0]   mem_wdata, mem_rdata;

    logic          accept;
    logic          last_ray;
    logic          miss;
    logic          advance;
    logic signed [63:0] den_f, tn_f, un_f;
    logic [89:0]   stx, sty;
    logic [47:0]   sq_try;
    logic [23:0]   d_cap;
    logic [IW-1:0] ridx_ext;
    logic [10:0]   base_w;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign read_ray  = read_ray_reg;
    assign distance  = distance_reg;
    assign ridx_ext  = IW'(ray_index);

    assign n_rays = (32'(ray_count_reg) > MAX_RAYS) ? CW'(MAX_RAYS) : CW'(ray_count_reg);
    assign last_ray = (CW'(cnt_reg + 1'b1) == n_rays);

    function automatic logic [89:0] md_step(
        input logic [64:0] rem,
        input logic [24:0] q,
        input logic [62:0] num,
        input logic [62:0] den,
        input logic        mb
    );
        logic [64:0] r;
        logic [24:0] qq;
        r  = {rem[63:0], 1'b0};
        qq = {q[23:0], 1'b0};
        if (r >= {2'b00, den}) begin
            r  = r - {2'b00, den};
            qq = qq + 25'd1;
        end
        if (mb) begin
            r = r + {2'b00, num};
            if (r >= {2'b00, den}) begin
                r  = r - {2'b00, den};
                qq = qq + 25'd1;
            end
        end
        return {r, qq};
    endfunction

    function automatic logic signed [63:0] flip64(input logic signed [63:0] v);
        return (v == S64_MIN) ? S64_MAX : -v;
    endfunction

    // first ray angle, wrapped into 0..359
    always_comb
    begin
        base_w = 11'(heading_reg) + 11'($unsigned(11'(min_angle_reg))) + 11'd720;
        for (int k = 0; k < 4; k++) begin
            if (base_w >= 11'd360) base_w = base_w - 11'd360;
        end
        angle0 = base_w[8:0];
    end

    always_comb
    begin
        den_f = (den_reg < 0) ? flip64(den_reg) : den_reg;
        tn_f  = (den_reg < 0) ? flip64(tn_reg)  : tn_reg;
        un_f  = (den_reg < 0) ? flip64(un_reg)  : un_reg;
        miss  = (den_reg == 0) || (tn_f < 0) || (tn_f > den_f)
                || (un_f < 0) || (un_f > den_f);
    end

    assign stx    = md_step(remx_reg, qx_reg, num_reg, dv_reg, mulx_reg[div_cnt_reg]);
    assign sty    = md_step(remy_reg, qy_reg, num_reg, dv_reg, muly_reg[div_cnt_reg]);
    assign sq_try = sq_res_reg + sq_bit_reg;
    assign d_cap  = (sq_res_reg[23:0] > {1'b0, max_range_reg})
                    ? {1'b0, max_range_reg} : sq_res_reg[23:0];
    assign advance = ((state_reg == S_TEST) && miss) || (state_reg == S_WB);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:   if (cnt_reg == CW'(MAX_RAYS - 1)) state_next = S_IDLE;
            S_IDLE:
            begin
                if (accept) begin
                    unique case (cmd)
                        CMD_SEGMENT: state_next = S_SEG_MUL;
                        CMD_READ:    state_next = S_RD;
                        CMD_CLEAR:   state_next = S_CLEAR;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_RD:      state_next = S_IDLE;
            S_SEG_MUL: state_next = S_SEG_TN;
            S_SEG_TN:  state_next = (n_rays == '0) ? S_IDLE : S_TRIG;
            S_TRIG:    state_next = S_RVEC;
            S_RVEC:    state_next = S_CROSS;
            S_CROSS:   state_next = S_DEN;
            S_DEN:     state_next = S_TEST;
            S_TEST:    state_next = miss ? (last_ray ? S_IDLE : S_TRIG) : S_DIV;
            S_DIV:     if (div_cnt_reg == 5'd0) state_next = S_SQ;
            S_SQ:      state_next = S_SUM;
            S_SUM:     state_next = S_SQRT;
            S_SQRT:    if (sq_bit_reg == 48'd1) state_next = S_WB;
            S_WB:      state_next = last_ray ? S_IDLE : S_TRIG;
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb
    begin
        busy      = (state_reg != S_IDLE);
        mem_we    = 1'b0;
        mem_waddr = cnt_reg[AW-1:0];
        mem_wdata = fill_reg;
        mem_raddr = cnt_reg[AW-1:0];
        unique case (state_reg)
            S_CLEAR: mem_we = 1'b1;
            S_IDLE:  mem_raddr = ridx_ext[AW-1:0];
            S_WB:
            begin
                mem_we    = (d_cap[22:0] < cur_reg);
                mem_wdata = d_cap[22:0];
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        mem_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            heading_reg   <= '0;
            min_angle_reg <= '0;
            ray_count_reg <= 9'd360;
            max_range_reg <= RANGE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ORIGIN_X:  origin_x_reg  <= $signed(cfg_data);
                REG_ORIGIN_Y:  origin_y_reg  <= $signed(cfg_data);
                REG_HEADING:   heading_reg   <= cfg_data[8:0];
                REG_MIN_ANGLE: min_angle_reg <= $signed(cfg_data[9:0]);
                REG_RAY_COUNT: ray_count_reg <= cfg_data[8:0];
                REG_MAX_RANGE: max_range_reg <= cfg_data[22:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            fill_reg  <= RANGE_RESET;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_RD);
            if (state_reg == S_CLEAR) cnt_reg <= CW'(cnt_reg + 1'b1);
            if (accept && (cmd == CMD_CLEAR)) begin
                fill_reg <= max_range_reg;
                cnt_reg  <= '0;
            end
            if (state_reg == S_SEG_TN) cnt_reg <= '0;
            if (advance) cnt_reg <= CW'(cnt_reg + 1'b1);
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (accept) begin
            rd_idx_reg <= ray_index;
            oor_reg    <= (32'(ray_index) >= MAX_RAYS);
            sx_reg     <= SW'(seg_end_x) - SW'(seg_start_x);
            sy_reg     <= SW'(seg_end_y) - SW'(seg_start_y);
            wx_reg     <= WW'(seg_start_x) - WW'(origin_x_reg);
            wy_reg     <= WW'(seg_start_y) - WW'(origin_y_reg);
        end

        if (state_reg == S_RD) begin
            read_ray_reg <= rd_idx_reg;
            distance_reg <= (oor_reg || (mem_rdata >= max_range_reg))
                            ? max_range_reg : mem_rdata;
        end

        if (state_reg == S_SEG_MUL) begin
            tp1_reg   <= 64'(PW_WS'(wx_reg) * PW_WS'(sy_reg));
            tp2_reg   <= 64'(PW_WS'(wy_reg) * PW_WS'(sx_reg));
            angle_reg <= angle0;
        end
        if (state_reg == S_SEG_TN) tn_reg <= tp1_reg - tp2_reg;

        if (state_reg == S_TRIG) begin
            prx_reg <= sin_deg((angle_reg >= 9'd270) ? angle_reg - 9'd270
                                                      : angle_reg + 9'd90)
                       * $signed({1'b0, max_range_reg});
            pry_reg <= sin_deg(angle_reg) * $signed({1'b0, max_range_reg});
        end
        if (state_reg == S_RVEC) begin
            rx_reg  <= 24'((prx_reg + 40'sd16384) >>> 15);
            ry_reg  <= 24'((pry_reg + 40'sd16384) >>> 15);
            cur_reg <= mem_rdata;
        end
        if (state_reg == S_CROSS) begin
            dp1_reg <= 64'(PW_RS'(rx_reg) * PW_RS'(sy_reg));
            dp2_reg <= 64'(PW_RS'(ry_reg) * PW_RS'(sx_reg));
            up1_reg <= 64'(PW_WR'(wx_reg) * PW_WR'(ry_reg));
            up2_reg <= 64'(PW_WR'(wy_reg) * PW_WR'(rx_reg));
        end
        if (state_reg == S_DEN) begin
            den_reg <= dp1_reg - dp2_reg;
            un_reg  <= up1_reg - up2_reg;
        end

        if (state_reg == S_TEST) begin
            num_reg     <= tn_f[62:0];
            dv_reg      <= den_f[62:0];
            mulx_reg    <= (rx_reg < 0) ? 24'(-rx_reg) : 24'(rx_reg);
            muly_reg    <= (ry_reg < 0) ? 24'(-ry_reg) : 24'(ry_reg);
            remx_reg    <= '0;
            remy_reg    <= '0;
            qx_reg      <= '0;
            qy_reg      <= '0;
            div_cnt_reg <= 5'd23;
        end
        if (state_reg == S_DIV) begin
            {remx_reg, qx_reg} <= stx;
            {remy_reg, qy_reg} <= sty;
            div_cnt_reg        <= div_cnt_reg - 5'd1;
        end

        if (state_reg == S_SQ) begin
            hx2_reg <= qx_reg[23:0] * qx_reg[23:0];
            hy2_reg <= qy_reg[23:0] * qy_reg[23:0];
        end
        if (state_reg == S_SUM) begin
            sq_n_reg   <= hx2_reg + hy2_reg;
            sq_res_reg <= '0;
            sq_bit_reg <= 48'd1 << 46;
        end
        if (state_reg == S_SQRT) begin
            if (sq_n_reg >= sq_try) begin
                sq_n_reg   <= sq_n_reg - sq_try;
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end else begin
                sq_res_reg <= sq_res_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end

        // step to the next ray, wrap the angle at 360
        if (advance) angle_reg <= (angle_reg == 9'd359) ? 9'd0 : angle_reg + 9'd1;
    end

    a_done_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_RD))
        else $error("result strobe without a read");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("store written while idle");

    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd != CMD_NOP)) |=> busy)
        else $error("command transfer did not raise busy");

    a_div_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_cnt_reg <= 5'd23))
        else $error("divider step count out of range");

endmodule

`default_nettype wire

### tb/sv/lidar_ray_segment_caster_checker.sv
`timescale 1ns / 1ps

module lidar_ray_segment_caster_checker
    import lrsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         cmd,
    input  logic signed [23:0] seg_start_x,
    input  logic signed [23:0] seg_start_y,
    input  logic signed [23:0] seg_end_x,
    input  logic signed [23:0] seg_end_y,
    input  logic [8:0]         ray_index,
    input  logic               done,
    input  logic [8:0]         read_ray,
    input  logic [22:0]        distance,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    output int                 mismatches,
    output int                 outstanding
);

    localparam int RAYS = 360;

    typedef struct packed {
        logic [8:0]  ray;
        logic [22:0] len;
    } range_read_t;

    range_read_t pending_reads[$];

    logic [22:0]        nearest[RAYS];
    logic signed [23:0] pose_x;
    logic signed [23:0] pose_y;
    logic [8:0]         heading_deg;
    logic signed [9:0]  fan_start;
    logic [8:0]         fan_size;
    logic [22:0]        reach;
    longint             sine_q15[91];

    function automatic longint sine_at(int a);
        if (a <= 90)  return sine_q15[a];
        if (a <= 180) return sine_q15[180 - a];
        if (a <= 270) return -sine_q15[a - 180];
        return -sine_q15[360 - a];
    endfunction

    function automatic longint int_sqrt(longint n);
        longint root;
        longint cand;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            cand = root | (longint'(1) << b);
            if (cand * cand <= n) root = cand;
        end
        return root;
    endfunction

    // Cast one wall against the fan, keep the nearest hit per ray.
    task automatic cast_wall(longint px, longint py, longint qx, longint qy);
        longint      sx, sy, wx, wy, rx, ry, den, tn, un, hx, hy, d;
        int          base, a, n;
        logic [127:0] prod;
        sx = qx - px;
        sy = qy - py;
        wx = px - longint'(pose_x);
        wy = py - longint'(pose_y);
        base = int'(heading_deg) + int'(fan_start);
        n = (fan_size > RAYS) ? RAYS : int'(fan_size);
        for (int i = 0; i < n; i++) begin
            a = (base + i) % 360;
            if (a < 0) a += 360;
            rx = (sine_at((a + 90) % 360) * longint'(reach) + 16384) >>> 15;
            ry = (sine_at(a) * longint'(reach) + 16384) >>> 15;
            den = rx * sy - ry * sx;
            tn = wx * sy - wy * sx;
            un = wx * ry - wy * rx;
            if (den == 0) continue;
            if (den < 0) begin
                den = -den;
                tn = -tn;
                un = -un;
            end
            if (tn < 0 || tn > den || un < 0 || un > den) continue;
            prod = 128'(tn) * 128'(rx < 0 ? -rx : rx);
            hx = longint'(prod / 128'(den));
            prod = 128'(tn) * 128'(ry < 0 ? -ry : ry);
            hy = longint'(prod / 128'(den));
            d = int_sqrt(hx * hx + hy * hy);
            if (d > longint'(reach)) d = longint'(reach);
            if (d < longint'(nearest[i])) nearest[i] = 23'(d);
        end
    endtask

    initial
    begin
        logic [63:0] x, x2, t, q;
        longint      sum;
        for (int d = 0; d <= 90; d++) begin
            x = 64'(d) * PI_Q30 / 64'd180;
            x2 = (x * x) >> 30;
            t = x;
            sum = longint'(x);
            for (int k = 1; k <= 7; k++) begin
                t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) sum -= longint'(t);
                else sum += longint'(t);
            end
            if (sum < 0) sum = 0;
            q = (64'(sum) + 64'd16384) >> 15;
            if (q > 64'd32767) q = 64'd32767;
            sine_q15[d] = longint'(q);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        range_read_t exp_read;
        if (!rst_n) begin
            pose_x = '0;
            pose_y = '0;
            heading_deg = '0;
            fan_start = '0;
            fan_size = 9'd360;
            reach = RANGE_RESET;
            for (int i = 0; i < RAYS; i++) nearest[i] = RANGE_RESET;
            pending_reads.delete();
            mismatches = 0;
            outstanding = 0;
        end else begin
            // a read issued this edge strobes later, so check the strobe first
            if (done) begin
                if (pending_reads.size() == 0) begin
                    $display("%0t: unexpected read result ray=%0d distance=%0d",
                             $time, read_ray, distance);
                    mismatches++;
                end else begin
                    exp_read = pending_reads.pop_front();
                    if (read_ray !== exp_read.ray) begin
                        $display("%0t: read_ray expected %0d actual %0d",
                                 $time, exp_read.ray, read_ray);
                        mismatches++;
                    end
                    if (distance !== exp_read.len) begin
                        $display("%0t: distance (ray %0d) expected %0d actual %0d",
                                 $time, exp_read.ray, exp_read.len, distance);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ORIGIN_X:  pose_x = cfg_data;
                    REG_ORIGIN_Y:  pose_y = cfg_data;
                    REG_HEADING:   heading_deg = cfg_data[8:0];
                    REG_MIN_ANGLE: fan_start = cfg_data[9:0];
                    REG_RAY_COUNT: fan_size = cfg_data[8:0];
                    REG_MAX_RANGE: reach = cfg_data[22:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                case (cmd)
                    CMD_SEGMENT: cast_wall(seg_start_x, seg_start_y, seg_end_x, seg_end_y);
                    CMD_CLEAR:   for (int i = 0; i < RAYS; i++) nearest[i] = reach;
                    CMD_READ: begin
                        exp_read.ray = ray_index;
                        exp_read.len = reach;
                        if (ray_index < RAYS && nearest[ray_index] < reach)
                            exp_read.len = nearest[ray_index];
                        pending_reads.push_back(exp_read);
                    end
                    default: ;
                endcase
            end
            outstanding = pending_reads.size();
        end
    end

endmodule

### tb/sv/lidar_ray_segment_caster_tb.sv
`timescale 1ns / 1ps

module lidar_ray_segment_caster_tb;
    import lrsc_pkg::*;

    localparam longint CYCLE_LIMIT = 6000000;
    localparam longint COORD_MIN = -8388608;
    localparam longint COORD_MAX = 8388607;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         cmd;
    logic signed [23:0] seg_start_x;
    logic signed [23:0] seg_start_y;
    logic signed [23:0] seg_end_x;
    logic signed [23:0] seg_end_y;
    logic [8:0]         ray_index;
    logic               done;
    logic [8:0]         read_ray;
    logic [22:0]        distance;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [23:0]        cfg_data;
    int                 mismatches;
    int                 outstanding;

    longint             cycles;
    int                 burst_left;
    longint             cur_ox, cur_oy, cur_range;
    int                 cur_count;

    lidar_ray_segment_caster i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
        .seg_end_x(seg_end_x), .seg_end_y(seg_end_y), .ray_index(ray_index),
        .done(done), .read_ray(read_ray), .distance(distance),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    lidar_ray_segment_caster_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
        .seg_end_x(seg_end_x), .seg_end_y(seg_end_y), .ray_index(ray_index),
        .done(done), .read_ray(read_ray), .distance(distance),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic logic signed [23:0] clamp_coord(longint v);
        if (v < COORD_MIN) return 24'(COORD_MIN);
        if (v > COORD_MAX) return 24'(COORD_MAX);
        return 24'(v);
    endfunction

    // Called at a falling edge; returns at a falling edge after the transfer.
    task automatic issue(logic [1:0] c, logic signed [23:0] px, logic signed [23:0] py,
                         logic signed [23:0] qx, logic signed [23:0] qy, logic [8:0] idx);
        logic taken;
        start = 1'b1;
        cmd = c;
        seg_start_x = px;
        seg_start_y = py;
        seg_end_x = qx;
        seg_end_y = qy;
        ray_index = idx;
        forever begin
            taken = !busy;
            @(posedge clk);
            @(negedge clk);
            if (taken) break;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        forever begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data = 24'($urandom);
    endtask

    // Drop start and hold until every read has returned and the block is free.
    task automatic drain();
        start = 1'b0;
        while (outstanding != 0 || busy) @(negedge clk);
        repeat (10) @(negedge clk);
        while (busy) @(negedge clk);
    endtask

    task automatic set_pose(longint ox, longint oy, int hdg, int amin, int cnt, longint rng);
        drain();
        write_reg(REG_ORIGIN_X, 24'(ox));
        write_reg(REG_ORIGIN_Y, 24'(oy));
        write_reg(REG_HEADING, 24'(hdg));
        write_reg(REG_MIN_ANGLE, 24'(amin));
        write_reg(REG_RAY_COUNT, 24'(cnt));
        write_reg(REG_MAX_RANGE, 24'(rng));
        cur_ox = ox;
        cur_oy = oy;
        cur_count = cnt;
        cur_range = rng;
    endtask

    // Wall placed around the sensor so that it can cross part of the fan.
    task automatic random_wall();
        longint span, ax, ay, bx, by;
        span = (cur_range > 0 && cur_range < 1000000) ? cur_range + 16 : 1000000;
        ax = cur_ox + longint'($urandom_range(0, 32'(2 * span))) - span;
        ay = cur_oy + longint'($urandom_range(0, 32'(2 * span))) - span;
        bx = cur_ox + longint'($urandom_range(0, 32'(2 * span))) - span;
        by = cur_oy + longint'($urandom_range(0, 32'(2 * span))) - span;
        if ($urandom_range(0, 9) == 0) bx = ax;
        issue(CMD_SEGMENT, clamp_coord(ax), clamp_coord(ay), clamp_coord(bx),
              clamp_coord(by), 9'($urandom));
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            random_wall();
        end else if (pick < 56) begin
            issue(CMD_SEGMENT, 24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom), 9'($urandom));
        end else if (pick < 88) begin
            issue(CMD_READ, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                  ($urandom_range(0, 4) == 0) ? 9'($urandom)
                  : 9'($urandom_range(0, (cur_count > 0 && cur_count <= 360) ?
                                         cur_count - 1 : 359)));
        end else if (pick < 94) begin
            issue(CMD_CLEAR, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                  9'($urandom));
        end else begin
            issue(CMD_NOP, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                  9'($urandom));
        end
    endtask

    initial
    begin
        longint rng;
        int     cnt;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_NOP;
        seg_start_x = '0;
        seg_start_y = '0;
        seg_end_x = '0;
        seg_end_y = '0;
        ray_index = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_ORIGIN_X;
        cfg_data = '0;
        burst_left = 0;
        cur_ox = 0;
        cur_oy = 0;
        cur_count = 360;
        cur_range = RANGE_RESET;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // directed: reset pose, touching ends, parallel, zero-length, extremes
        drain();
        issue(CMD_READ, '0, '0, '0, '0, 9'd0);
        issue(CMD_SEGMENT, 24'sd1000, -24'sd1000, 24'sd1000, 24'sd1000, '0);
        issue(CMD_SEGMENT, 24'sd500, 24'sd0, 24'sd500, 24'sd0, '0);
        issue(CMD_SEGMENT, 24'(COORD_MAX), 24'(COORD_MIN), 24'(COORD_MAX), 24'(COORD_MAX), '0);
        issue(CMD_READ, '0, '0, '0, '0, 9'd0);
        issue(CMD_READ, '0, '0, '0, '0, 9'd359);
        issue(CMD_READ, '0, '0, '0, '0, 9'd511);
        issue(CMD_NOP, '1, '1, '1, '1, '1);
        set_pose(0, 0, 0, 0, 4, 1000);
        // ray end touches x=1000, segment ends on the rays
        issue(CMD_SEGMENT, 24'sd1000, 24'sd0, 24'sd1000, 24'sd100, '0);
        issue(CMD_SEGMENT, 24'sd100, 24'sd0, 24'sd200, 24'sd0, '0);
        issue(CMD_SEGMENT, 24'sd300, -24'sd50, 24'sd300, 24'sd50, '0);
        for (int i = 0; i < 5; i++) issue(CMD_READ, '0, '0, '0, '0, 9'(i));
        set_pose(COORD_MIN, COORD_MAX, 511, -512, 0, 0);
        issue(CMD_SEGMENT, 24'(COORD_MIN), 24'(COORD_MIN), 24'(COORD_MAX), 24'(COORD_MAX), '0);
        issue(CMD_CLEAR, '0, '0, '0, '0, '0);
        issue(CMD_READ, '0, '0, '0, '0, 9'd3);
        set_pose(COORD_MAX, COORD_MIN, 359, 359, 511, RANGE_RESET);
        issue(CMD_SEGMENT, 24'(COORD_MIN), 24'(COORD_MIN), 24'(COORD_MAX), 24'(COORD_MAX), '0);
        issue(CMD_READ, '0, '0, '0, '0, 9'd45);
        set_pose(0, 0, 0, -360, 360, 500);
        issue(CMD_READ, '0, '0, '0, '0, 9'd100);

        for (int phase = 0; phase < 14; phase++) begin
            case ($urandom_range(0, 5))
                0:       rng = 0;
                1:       rng = RANGE_RESET;
                default: rng = $urandom_range(1, 200000);
            endcase
            cnt = (phase % 7 == 3) ? $urandom_range(300, 511) : $urandom_range(0, 24);
            set_pose(longint'($urandom_range(0, 8000000)) - 4000000,
                     longint'($urandom_range(0, 8000000)) - 4000000,
                     $urandom_range(0, 511), $urandom_range(0, 1023), cnt, rng);
            if ($urandom_range(0, 1) == 0)
                issue(CMD_CLEAR, '0, '0, '0, '0, '0);
            for (int k = 0; k < ((cnt > 100) ? 12 : 36); k++) random_item();
        end

        drain();
        while (busy) @(negedge clk);
        repeat (100) @(negedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
